/* sv/pidc_pkg.sv */
// Package with the shared constants, codes and types of the PWM input capture block.
package pidc_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int NUM_CHANNELS = 2;

    localparam int CAPTURE_W = 16;
    localparam int STORE_W   = (COUNT_WIDTH < CAPTURE_W) ? COUNT_WIDTH : CAPTURE_W;
    localparam int DEN_W     = STORE_W + 1;
    localparam int FRAC_W    = 16;
    localparam int DIV_W     = DEN_W + FRAC_W;
    localparam int STEP_W    = $clog2(DIV_W);
    localparam int TICK_W    = 28;
    localparam int DUTY_W    = FRAC_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000000);
    localparam logic [DUTY_W-1:0] DUTY_ONE   = DUTY_W'(65536);

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] PH_RISE1 = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_RISE2 = 2'd2;

    typedef logic [STORE_W-1:0] cnt_t;

    typedef struct packed {
        logic need_div;
        logic next_edge_falling;
        logic clear_timer;
        cnt_t high;
        cnt_t period;
    } job_t;

endpackage

/* sv/pwm_input_freq_duty_capture.sv */
// Top level of the two-channel PWM input frequency and duty capture block.
// Each request is either a capture edge or a read. Edges and reads that find no finished
// measurement pass the queue and the back end's result register to the result ports, at
// one request per cycle while the divider is idle and results are popped. A read with a
// finished measurement loads a restoring divider that forms frequency and duty side by side,
// runs 33 steps, then the result moves out; requests meanwhile go into a two-entry queue.
module pwm_input_freq_duty_capture
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic              command,
    input  logic              channel,
    input  logic [15:0]       captured_count,
    output logic              empty,
    input  logic              pop,
    output logic              next_edge_falling,
    output logic              clear_timer,
    output logic              measurement_valid,
    output logic [TICK_W-1:0] frequency_hz,
    output logic [DUTY_W-1:0] duty_q16
);

    logic [TICK_W-1:0] tick_rate_reg;
    logic              q_push;
    job_t              q_wr_job;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    job_t              q_rd_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= TICK_RESET;
        end
        else if (cfg_we)
        begin
            tick_rate_reg <= cfg_wdata;
        end
    end

    assign full = q_full;

    pidc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .command        (command),
        .channel        (channel),
        .captured_count (captured_count),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (q_wr_job)
    );

    pidc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_job   (q_wr_job),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_job   (q_rd_job)
    );

    pidc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick_rate         (tick_rate_reg),
        .q_valid           (q_valid),
        .q_job             (q_rd_job),
        .q_pop             (q_pop),
        .empty             (empty),
        .pop               (pop),
        .next_edge_falling (next_edge_falling),
        .clear_timer       (clear_timer),
        .measurement_valid (measurement_valid),
        .frequency_hz      (frequency_hz),
        .duty_q16          (duty_q16)
    );

    a_valid_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && measurement_valid) |-> (!clear_timer && !next_edge_falling))
        else $error("A valid measurement came with a timer clear or a falling-edge arm.");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !measurement_valid) |-> (frequency_hz == '0 && duty_q16 == '0))
        else $error("A result without a measurement carries a non-zero frequency or duty.");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (duty_q16 <= DUTY_ONE))
        else $error("The duty result exceeds one.");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("The back end took a job from an empty queue.");

endmodule

/* sv/pidc_front.sv */
// Front end: accepts requests, runs the per-channel edge sequencers and classifies each request.
module pidc_front
    import pidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        command,
    input  logic        channel,
    input  logic [15:0] captured_count,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic [1:0] phase_reg [NUM_CHANNELS];
    cnt_t       high_reg  [NUM_CHANNELS];
    cnt_t       period_reg[NUM_CHANNELS];
    logic       done_reg  [NUM_CHANNELS];

    logic       in_range;
    logic [1:0] phase_cur;
    logic [1:0] phase_next;
    cnt_t       high_next;
    cnt_t       period_next;
    logic       done_next;
    cnt_t       cnt;

    assign q_push   = push && !q_full;
    assign in_range = (32'(channel) < NUM_CHANNELS);
    assign cnt      = captured_count[STORE_W-1:0];

    always_comb
    begin
        phase_cur   = in_range ? phase_reg[channel] : PH_RISE1;
        phase_next  = phase_cur;
        high_next   = in_range ? high_reg[channel] : '0;
        period_next = in_range ? period_reg[channel] : '0;
        done_next   = in_range ? done_reg[channel] : 1'b0;
        q_job       = '0;
        if (in_range)
        begin
            if (command == CMD_EDGE)
            begin
                if (!done_next)
                begin
                    case (phase_cur)
                        PH_FALL:
                        begin
                            high_next  = cnt;
                            phase_next = PH_RISE2;
                        end
                        PH_RISE2:
                        begin
                            period_next = cnt;
                            phase_next  = PH_RISE1;
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            period_next       = cnt;
                            phase_next        = PH_FALL;
                            q_job.clear_timer = 1'b1;
                        end
                    endcase
                end
            end
            else if (done_next)
            begin
                q_job.need_div = 1'b1;
                q_job.high     = high_next;
                q_job.period   = period_next;
                done_next      = 1'b0;
            end
            q_job.next_edge_falling = (phase_next == PH_FALL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                phase_reg[i]  <= PH_RISE1;
                high_reg[i]   <= '0;
                period_reg[i] <= '0;
                done_reg[i]   <= 1'b0;
            end
        end
        else if (q_push && in_range)
        begin
            phase_reg[channel]  <= phase_next;
            high_reg[channel]   <= high_next;
            period_reg[channel] <= period_next;
            done_reg[channel]   <= done_next;
        end
    end

endmodule

/* sv/pidc_queue.sv */
// Short queue of classified jobs between the front end and the back end.
module pidc_queue
    import pidc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output job_t rd_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* sv/pidc_back.sv */
// Back end: bit-serial frequency and duty division and the result register.
module pidc_back
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TICK_W-1:0] tick_rate,
    input  logic              q_valid,
    input  job_t              q_job,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic              next_edge_falling,
    output logic              clear_timer,
    output logic              measurement_valid,
    output logic [TICK_W-1:0] frequency_hz,
    output logic [DUTY_W-1:0] duty_q16
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        st_reg,   st_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  fa_reg,   fa_next;
    logic [DEN_W-1:0]  fr_reg,   fr_next;
    logic [DIV_W-1:0]  da_reg,   da_next;
    logic [DEN_W-1:0]  dr_reg,   dr_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic              nef_reg,  nef_next;

    logic              out_valid_reg, out_valid_next;
    logic              nef_out_reg,   nef_out_next;
    logic              clr_out_reg,   clr_out_next;
    logic              mv_out_reg,    mv_out_next;
    logic [TICK_W-1:0] freq_out_reg,  freq_out_next;
    logic [DUTY_W-1:0] duty_out_reg,  duty_out_next;

    logic              slot_free;
    logic [DIV_W-1:0]  fa_step, da_step;
    logic [DEN_W-1:0]  fr_step, dr_step;

    function automatic logic [DIV_W+DEN_W-1:0] div_step(
        input logic [DIV_W-1:0] acc,
        input logic [DEN_W-1:0] rem,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0]   shifted;
        logic             qbit;
        logic [DEN_W-1:0] rem_new;
        shifted = {rem, acc[DIV_W-1]};
        qbit    = (shifted >= {1'b0, den});
        rem_new = qbit ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
        return {acc[DIV_W-2:0], qbit, rem_new};
    endfunction

    assign slot_free = !out_valid_reg || pop;
    assign {fa_step, fr_step} = div_step(fa_reg, fr_reg, den_reg);
    assign {da_step, dr_step} = div_step(da_reg, dr_reg, den_reg);

    always_comb
    begin
        st_next        = st_reg;
        step_next      = step_reg;
        fa_next        = fa_reg;
        fr_next        = fr_reg;
        da_next        = da_reg;
        dr_next        = dr_reg;
        den_next       = den_reg;
        nef_next       = nef_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        nef_out_next   = nef_out_reg;
        clr_out_next   = clr_out_reg;
        mv_out_next    = mv_out_reg;
        freq_out_next  = freq_out_reg;
        duty_out_next  = duty_out_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && q_job.need_div)
                begin
                    q_pop     = 1'b1;
                    st_next   = ST_DIV;
                    step_next = STEP_W'(DIV_W - 1);
                    fa_next   = DIV_W'(tick_rate);
                    fr_next   = '0;
                    da_next   = {{1'b0, q_job.high} + 1'b1, {FRAC_W{1'b0}}};
                    dr_next   = '0;
                    den_next  = {1'b0, q_job.period} + 1'b1;
                    nef_next  = q_job.next_edge_falling;
                end
                else if (q_valid && slot_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    nef_out_next   = q_job.next_edge_falling;
                    clr_out_next   = q_job.clear_timer;
                    mv_out_next    = 1'b0;
                    freq_out_next  = '0;
                    duty_out_next  = '0;
                end
            end
            ST_DIV:
            begin
                fa_next = fa_step;
                fr_next = fr_step;
                da_next = da_step;
                dr_next = dr_step;
                if (step_reg == '0)
                begin
                    st_next = ST_HOLD;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    st_next        = ST_IDLE;
                    out_valid_next = 1'b1;
                    nef_out_next   = nef_reg;
                    clr_out_next   = 1'b0;
                    mv_out_next    = 1'b1;
                    freq_out_next  = fa_reg[TICK_W-1:0];
                    duty_out_next  = (da_reg > DIV_W'(DUTY_ONE)) ? DUTY_ONE : da_reg[DUTY_W-1:0];
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        fa_reg       <= fa_next;
        fr_reg       <= fr_next;
        da_reg       <= da_next;
        dr_reg       <= dr_next;
        den_reg      <= den_next;
        nef_reg      <= nef_next;
        nef_out_reg  <= nef_out_next;
        clr_out_reg  <= clr_out_next;
        mv_out_reg   <= mv_out_next;
        freq_out_reg <= freq_out_next;
        duty_out_reg <= duty_out_next;
    end

    assign empty             = !out_valid_reg;
    assign next_edge_falling = nef_out_reg;
    assign clear_timer       = clr_out_reg;
    assign measurement_valid = mv_out_reg;
    assign frequency_hz      = freq_out_reg;
    assign duty_q16          = duty_out_reg;

endmodule
